### rtl/tde_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and arithmetic helpers for the tracker dropout
// extrapolator. No dependencies.
package tde_pkg;

  localparam int NUM_TRACKERS = 5;
  localparam int COORD_W      = 32;
  localparam int TRK_W        = 3;
  localparam int CNT_W        = 8;
  localparam int FILL_W       = 2;
  localparam int HIST_DEPTH   = 2;
  localparam int ADDR_W       = (NUM_TRACKERS > 1) ? $clog2(NUM_TRACKERS) : 1;
  localparam int STEP_W       = CNT_W + 1;
  localparam int DIFF_W       = COORD_W + 1;
  localparam int PROD_W       = DIFF_W + STEP_W + 1;
  localparam int SUM_W        = PROD_W + 1;

  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(HIST_DEPTH);

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]  diff_t;
  typedef logic signed [PROD_W-1:0]  prod_t;

  localparam coord_t COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } vec_t;

  typedef struct packed {
    diff_t x;
    diff_t y;
    diff_t z;
  } dvec_t;

  typedef struct packed {
    prod_t x;
    prod_t y;
    prod_t z;
  } pvec_t;

  // per-tracker state word held in RAM
  typedef struct packed {
    vec_t              newest;
    vec_t              older;
    logic [FILL_W-1:0] fill;
    logic [CNT_W-1:0]  lost;
  } trk_state_t;

  localparam int STATE_W = $bits(trk_state_t);

  // update stage -> arithmetic stage
  typedef struct packed {
    logic [TRK_W-1:0]  tracker;
    logic              valid_pose;
    logic              extrap;
    vec_t              base;
    dvec_t             diff;
    logic [STEP_W-1:0] steps;
  } ext_req_t;

  function automatic diff_t coord_diff(input coord_t a, input coord_t b);
    return {a[COORD_W-1], a} - {b[COORD_W-1], b};
  endfunction

  function automatic coord_t sat_add(input coord_t base, input prod_t p);
    logic [SUM_W-1:0]     sum;
    logic [SUM_W-COORD_W:0] hi;
    coord_t               res;
    sum = {{(SUM_W-COORD_W){base[COORD_W-1]}}, base} + {p[PROD_W-1], p};
    hi  = sum[SUM_W-1:COORD_W-1];
    if ((&hi) || (~|hi)) begin
      res = sum[COORD_W-1:0];
    end else if (sum[SUM_W-1]) begin
      res = COORD_MIN;
    end else begin
      res = COORD_MAX;
    end
    return res;
  endfunction

endpackage

### rtl/tde_ifs.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces: sample input, result output, config write.
// Depends on tde_pkg.
interface tde_in_if;
  logic                         valid;
  logic                         ready;
  logic [tde_pkg::TRK_W-1:0]    tracker_id;
  logic                         measured_ok;
  logic [tde_pkg::COORD_W-1:0]  meas_x;
  logic [tde_pkg::COORD_W-1:0]  meas_y;
  logic [tde_pkg::COORD_W-1:0]  meas_z;

  modport source (output valid, tracker_id, measured_ok, meas_x, meas_y, meas_z,
                  input ready);
  modport sink   (input valid, tracker_id, measured_ok, meas_x, meas_y, meas_z,
                  output ready);
endinterface

interface tde_out_if;
  logic                         valid;
  logic                         ready;
  logic [tde_pkg::TRK_W-1:0]    out_tracker;
  logic                         valid_pose;
  logic                         extrapolated;
  logic [tde_pkg::COORD_W-1:0]  rep_x;
  logic [tde_pkg::COORD_W-1:0]  rep_y;
  logic [tde_pkg::COORD_W-1:0]  rep_z;

  modport source (output valid, out_tracker, valid_pose, extrapolated, rep_x, rep_y,
                  rep_z, input ready);
  modport sink   (input valid, out_tracker, valid_pose, extrapolated, rep_x, rep_y,
                  rep_z, output ready);
endinterface

interface tde_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [tde_pkg::CNT_W-1:0]  max_dropout_frames;

  modport source (output valid, max_dropout_frames, input ready);
  modport sink   (input valid, max_dropout_frames, output ready);
endinterface

### rtl/tde_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tde_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/tde_update.sv
`timescale 1ns / 1ps
// Per-tracker state read-modify-write: state RAM, entry valid bits, write bypass.
// Depends on tde_pkg, tde_ifs, tde_ram.
module tde_update (
  input  logic                      clk,
  input  logic                      rst_n,
  tde_in_if.sink                    in_ch,
  input  logic [tde_pkg::CNT_W-1:0] max_dropout,
  input  logic                      req_ready,
  output logic                      req_valid,
  output tde_pkg::ext_req_t         req
);
  import tde_pkg::*;

  logic                    accept;
  logic                    in_range;
  logic [ADDR_W-1:0]       rd_addr;

  logic                    s1_v_r, s1_v_nxt;
  logic [TRK_W-1:0]        s1_id_r;
  logic                    s1_ok_r;
  logic                    s1_inr_r;
  logic                    s1_ent_r;
  vec_t                    s1_meas_r;
  logic [ADDR_W-1:0]       s1_addr;

  logic [NUM_TRACKERS-1:0] ent_vld_r, ent_vld_nxt;

  logic                    byp_v_r;
  logic [ADDR_W-1:0]       byp_addr_r;
  trk_state_t              byp_data_r;

  logic [STATE_W-1:0]      ram_rdata;
  trk_state_t              cur;
  trk_state_t              nxt_state;
  logic                    can_extrap;
  logic                    we;

  assign in_ch.ready = !s1_v_r || req_ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign in_range    = int'(in_ch.tracker_id) < NUM_TRACKERS;
  assign rd_addr     = in_ch.tracker_id[ADDR_W-1:0];
  assign s1_addr     = s1_id_r[ADDR_W-1:0];
  assign we          = s1_v_r && req_ready && s1_inr_r;
  assign req_valid   = s1_v_r;
  assign s1_v_nxt    = accept || (s1_v_r && !req_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r    <= 1'b0;
      ent_vld_r <= '0;
      byp_v_r   <= 1'b0;
    end else begin
      s1_v_r    <= s1_v_nxt;
      ent_vld_r <= ent_vld_nxt;
      if (we) begin
        byp_v_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_id_r   <= in_ch.tracker_id;
      s1_ok_r   <= in_ch.measured_ok;
      s1_inr_r  <= in_range;
      s1_ent_r  <= in_range && ent_vld_r[rd_addr];
      s1_meas_r <= {in_ch.meas_x, in_ch.meas_y, in_ch.meas_z};
    end
    if (we) begin
      byp_addr_r <= s1_addr;
      byp_data_r <= nxt_state;
    end
  end

  always_comb begin
    ent_vld_nxt = ent_vld_r;
    if (we) begin
      ent_vld_nxt[s1_addr] = 1'b1;
    end
  end

  tde_ram #(
    .WIDTH (STATE_W),
    .DEPTH (NUM_TRACKERS)
  ) u_state_ram (
    .clk   (clk),
    .we    (we),
    .waddr (s1_addr),
    .wdata (nxt_state),
    .re    (accept && in_range),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  always_comb begin
    if (byp_v_r && (byp_addr_r == s1_addr)) begin
      cur = byp_data_r;
    end else if (s1_ent_r) begin
      cur = trk_state_t'(ram_rdata);
    end else begin
      cur = '0;
    end

    can_extrap = !s1_ok_r && (max_dropout != '0) && (cur.fill == FILL_FULL) &&
                 (cur.lost < max_dropout);

    nxt_state      = cur;
    req.tracker    = s1_id_r;
    req.valid_pose = 1'b0;
    req.extrap     = 1'b0;
    req.base       = '0;
    req.diff       = '0;
    req.steps      = '0;

    if (s1_inr_r) begin
      if (s1_ok_r) begin
        nxt_state.older  = cur.newest;
        nxt_state.newest = s1_meas_r;
        nxt_state.fill   = (cur.fill == FILL_FULL) ? FILL_FULL : cur.fill + FILL_W'(1);
        nxt_state.lost   = '0;
        req.valid_pose   = 1'b1;
        req.base         = s1_meas_r;
      end else begin
        // shown location is always newest + slope * lost
        req.base   = cur.newest;
        req.diff.x = coord_diff(cur.newest.x, cur.older.x);
        req.diff.y = coord_diff(cur.newest.y, cur.older.y);
        req.diff.z = coord_diff(cur.newest.z, cur.older.z);
        if (can_extrap) begin
          nxt_state.lost = cur.lost + CNT_W'(1);
          req.valid_pose = 1'b1;
          req.extrap     = 1'b1;
          req.steps      = {1'b0, cur.lost} + STEP_W'(1);
        end else begin
          req.steps = {1'b0, cur.lost};
        end
      end
    end
  end

  a_meas_resets: assert property (@(posedge clk) disable iff (!rst_n)
    (we && s1_ok_r) |-> (nxt_state.lost == '0 && nxt_state.newest == s1_meas_r))
    else $error("measured word did not reset dropout state");

  a_lost_keeps_hist: assert property (@(posedge clk) disable iff (!rst_n)
    (we && !s1_ok_r) |-> (nxt_state.newest == cur.newest && nxt_state.older == cur.older))
    else $error("history changed on a lost word");

  a_extrap_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (req_valid && req.extrap) |-> (req.steps != '0 && req.valid_pose))
    else $error("extrapolation with zero steps");

  a_bypass_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    we |=> (byp_v_r && byp_addr_r == $past(s1_addr)))
    else $error("bypass register missed a write");

endmodule

### rtl/tde_extrap.sv
`timescale 1ns / 1ps
// Slope multiply stage and saturating add into the output register.
// Depends on tde_pkg, tde_ifs.
module tde_extrap (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              req_valid,
  input  tde_pkg::ext_req_t req,
  output logic              req_ready,
  tde_out_if.source         out_ch
);
  import tde_pkg::*;

  logic             s2_v_r, s2_v_nxt;
  logic [TRK_W-1:0] s2_trk_r;
  logic             s2_vp_r;
  logic             s2_ex_r;
  vec_t             s2_base_r;
  pvec_t            s2_prod_r;
  pvec_t            prod;

  logic             out_v_r, out_v_nxt;
  logic [TRK_W-1:0] out_trk_r;
  logic             out_vp_r;
  logic             out_ex_r;
  vec_t             out_pos_r;
  logic             out_free;

  assign out_free  = !out_v_r || out_ch.ready;
  assign req_ready = !s2_v_r || out_free;
  assign s2_v_nxt  = (req_valid && req_ready) || (s2_v_r && !out_free);
  assign out_v_nxt = (s2_v_r && out_free) || (out_v_r && !out_ch.ready);

  assign prod.x = $signed(req.diff.x) * $signed({1'b0, req.steps});
  assign prod.y = $signed(req.diff.y) * $signed({1'b0, req.steps});
  assign prod.z = $signed(req.diff.z) * $signed({1'b0, req.steps});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s2_v_r  <= s2_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      s2_trk_r  <= req.tracker;
      s2_vp_r   <= req.valid_pose;
      s2_ex_r   <= req.extrap;
      s2_base_r <= req.base;
      s2_prod_r <= prod;
    end
    if (s2_v_r && out_free) begin
      out_trk_r   <= s2_trk_r;
      out_vp_r    <= s2_vp_r;
      out_ex_r    <= s2_ex_r;
      out_pos_r.x <= sat_add(s2_base_r.x, s2_prod_r.x);
      out_pos_r.y <= sat_add(s2_base_r.y, s2_prod_r.y);
      out_pos_r.z <= sat_add(s2_base_r.z, s2_prod_r.z);
    end
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.out_tracker  = out_trk_r;
  assign out_ch.valid_pose   = out_vp_r;
  assign out_ch.extrapolated = out_ex_r;
  assign out_ch.rep_x        = out_pos_r.x;
  assign out_ch.rep_y        = out_pos_r.y;
  assign out_ch.rep_z        = out_pos_r.z;

  a_extrap_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_ch.extrapolated) |-> out_ch.valid_pose)
    else $error("extrapolated word without valid pose");

  a_meas_no_slope: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_v_r && s2_vp_r && !s2_ex_r) |-> (s2_prod_r == '0))
    else $error("measured word carries a slope term");

  a_s2_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_v_r && out_free) |=> out_v_r)
    else $error("word lost between product and output stage");

endmodule

### rtl/tracker_dropout_extrapolator.sv
`timescale 1ns / 1ps
// Top level of the tracker dropout extrapolator: config register and stage wiring.
// Depends on tde_pkg, tde_ifs, tde_update, tde_extrap.
//
// Takes one sample word per clock and returns one result word per sample, in
// order, through the state read, slope multiply and saturating add into the
// output register. Per-tracker history, history fill and dropout count sit in a
// small RAM with registered read; the entry is written back when its word leaves
// the state-read stage, and a one-entry bypass register serves a word that
// follows for the same tracker, so back-to-back words need no stall. The last
// reported position is rebuilt from the history and dropout count. Entries read
// as zero until first written, so no clearing pass runs after reset. Ready only
// drops when the output register and both internal stages are full.
// max_dropout_frames may be written only while no word is in flight.
module tracker_dropout_extrapolator (
  input  logic       clk,
  input  logic       rst_n,
  tde_in_if.sink     in_ch,
  tde_out_if.source  out_ch,
  tde_cfg_if.sink    cfg_ch
);
  import tde_pkg::*;

  logic [CNT_W-1:0] max_drop_r;
  logic             req_valid;
  logic             req_ready;
  ext_req_t         req;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_drop_r <= '0;
    end else if (cfg_ch.valid) begin
      max_drop_r <= cfg_ch.max_dropout_frames;
    end
  end

  tde_update u_update (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .max_dropout (max_drop_r),
    .req_ready   (req_ready),
    .req_valid   (req_valid),
    .req         (req)
  );

  tde_extrap u_extrap (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req       (req),
    .req_ready (req_ready),
    .out_ch    (out_ch)
  );

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for tracker_dropout_extrapolator: random and directed sample words
// against a scoreboard that predicts extrapolated, measured and held poses.
// Depends on tde_pkg, tde_ifs and the RTL top level.
import tde_pkg::*;

typedef struct {
  logic [TRK_W-1:0] tracker;
  logic             valid_pose;
  logic             extrapolated;
  vec_t             pos;
} pose_rec_t;

class pose_scoreboard;
  logic [CNT_W-1:0] dropout_limit;
  vec_t             last_meas [NUM_TRACKERS];
  vec_t             prev_meas [NUM_TRACKERS];
  vec_t             shown     [NUM_TRACKERS];
  int unsigned      fill      [NUM_TRACKERS];
  int unsigned      lost      [NUM_TRACKERS];
  pose_rec_t        expected_poses [$];
  int unsigned      failures;

  function new();
    dropout_limit = '0;
    failures = 0;
    for (int t = 0; t < NUM_TRACKERS; t++) begin
      last_meas[t] = '0;
      prev_meas[t] = '0;
      shown[t] = '0;
      fill[t] = 0;
      lost[t] = 0;
    end
  endfunction

  function void set_limit(logic [CNT_W-1:0] v);
    dropout_limit = v;
  endfunction

  function int pending();
    return expected_poses.size();
  endfunction

  // last + (last - prev) * steps, exact, then clamped to the coordinate range
  function coord_t project(coord_t last, coord_t prev, int unsigned steps);
    longint r;
    r = longint'(last) + (longint'(last) - longint'(prev)) * longint'(steps);
    if (r > longint'(COORD_MAX)) return COORD_MAX;
    if (r < longint'(COORD_MIN)) return COORD_MIN;
    return coord_t'(r);
  endfunction

  function void note_sample(logic [TRK_W-1:0] id, logic ok, vec_t meas);
    pose_rec_t e;
    int        t;
    e.tracker = id;
    e.valid_pose = 1'b0;
    e.extrapolated = 1'b0;
    e.pos = '0;
    if (id < NUM_TRACKERS) begin
      t = int'(id);
      if (ok) begin
        prev_meas[t] = last_meas[t];
        last_meas[t] = meas;
        if (fill[t] < HIST_DEPTH) fill[t]++;
        lost[t] = 0;
        e.valid_pose = 1'b1;
        e.pos = meas;
      end else if (dropout_limit != 0 && fill[t] >= HIST_DEPTH && lost[t] < dropout_limit) begin
        e.pos.x = project(last_meas[t].x, prev_meas[t].x, lost[t] + 1);
        e.pos.y = project(last_meas[t].y, prev_meas[t].y, lost[t] + 1);
        e.pos.z = project(last_meas[t].z, prev_meas[t].z, lost[t] + 1);
        lost[t]++;
        e.valid_pose = 1'b1;
        e.extrapolated = 1'b1;
      end else begin
        e.pos = shown[t];
      end
      shown[t] = e.pos;
    end
    expected_poses.push_back(e);
  endfunction

  function void field_check(string what, logic [COORD_W-1:0] want, logic [COORD_W-1:0] got);
    if (want !== got) begin
      failures++;
      $display("%0t mismatch %s: expected %h actual %h", $time, what, want, got);
    end
  endfunction

  function void check_report(logic [TRK_W-1:0] trk, logic vp, logic ex, vec_t pos);
    pose_rec_t e;
    if (expected_poses.size() == 0) begin
      failures++;
      $display("%0t unexpected result word: expected none actual tracker %h pos %h",
               $time, trk, pos);
      return;
    end
    e = expected_poses.pop_front();
    field_check("out_tracker", COORD_W'(e.tracker), COORD_W'(trk));
    field_check("valid_pose", COORD_W'(e.valid_pose), COORD_W'(vp));
    field_check("extrapolated", COORD_W'(e.extrapolated), COORD_W'(ex));
    field_check("rep_x", e.pos.x, pos.x);
    field_check("rep_y", e.pos.y, pos.y);
    field_check("rep_z", e.pos.z, pos.z);
  endfunction
endclass

module testbench;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES    = 300;

  logic clk;
  logic rst_n;

  tde_in_if  in_ch ();
  tde_out_if out_ch ();
  tde_cfg_if cfg_ch ();

  tracker_dropout_extrapolator u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  pose_scoreboard poses = new();

  int     send_idle_pct = 0;
  int     recv_idle_pct = 0;
  int     hold_request = 0;
  int     stall_cycles = 0;
  coord_t walk_pos [NUM_TRACKERS][3];
  coord_t walk_vel [NUM_TRACKERS][3];
  int     drop_left [NUM_TRACKERS];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result side: random back-pressure plus requested long hold-offs
  initial begin : result_side
    int hold_left;
    hold_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        out_ch.ready = 1'b0;
        hold_left--;
      end else begin
        out_ch.ready = ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      poses.check_report(out_ch.out_tracker, out_ch.valid_pose, out_ch.extrapolated,
                         vec_t'({out_ch.rep_x, out_ch.rep_y, out_ch.rep_z}));
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic vec_t vec3(coord_t a, coord_t b, coord_t c);
    vec_t v;
    v.x = a;
    v.y = b;
    v.z = c;
    return v;
  endfunction

  function automatic vec_t noise_vec();
    return vec_t'({$urandom, $urandom, $urandom});
  endfunction

  // mostly smooth motion, some jumps anywhere in range, some extremes
  function automatic coord_t fresh_coord(int t, int a);
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 80) begin
      if ($urandom_range(0, 9) == 0) walk_vel[t][a] = coord_t'(int'($urandom_range(0, 8192)) - 4096);
      walk_pos[t][a] = walk_pos[t][a] + walk_vel[t][a];
    end else if (pick < 92) begin
      walk_pos[t][a] = coord_t'($urandom);
    end else begin
      case ($urandom_range(0, 3))
        0:       walk_pos[t][a] = COORD_MIN;
        1:       walk_pos[t][a] = COORD_MAX;
        2:       walk_pos[t][a] = '0;
        default: walk_pos[t][a] = '1;
      endcase
    end
    return walk_pos[t][a];
  endfunction

  task automatic send_word(input logic [TRK_W-1:0] id, input logic ok, input vec_t meas);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.tracker_id = id;
    in_ch.measured_ok = ok;
    in_ch.meas_x = meas.x;
    in_ch.meas_y = meas.y;
    in_ch.meas_z = meas.z;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    poses.note_sample(id, ok, meas);
  endtask

  task automatic send_measured(input int t);
    vec_t m;
    m.x = fresh_coord(t, 0);
    m.y = fresh_coord(t, 1);
    m.z = fresh_coord(t, 2);
    send_word(TRK_W'(t), 1'b1, m);
  endtask

  task automatic drain();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (poses.pending() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  task automatic write_limit(input logic [CNT_W-1:0] v);
    @(negedge clk);
    cfg_ch.valid = 1'b1;
    cfg_ch.max_dropout_frames = v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    poses.set_limit(v);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic run_random(input int n_items, input int span);
    int t;
    for (int k = 0; k < n_items; k++) begin
      if ($urandom_range(0, 99) < 3) begin
        send_word(TRK_W'($urandom_range(NUM_TRACKERS, 7)), 1'($urandom_range(0, 1)), noise_vec());
      end else begin
        t = $urandom_range(0, NUM_TRACKERS - 1);
        if (drop_left[t] > 0) begin
          drop_left[t]--;
          send_word(TRK_W'(t), 1'b0, noise_vec());
        end else if ($urandom_range(0, 99) < 75) begin
          send_measured(t);
        end else begin
          drop_left[t] = $urandom_range(0, span);
          send_word(TRK_W'(t), 1'b0, noise_vec());
        end
      end
    end
  endtask

  // runs one tracker past the full dropout budget
  task automatic long_dropout(input int extra);
    int t;
    t = $urandom_range(0, NUM_TRACKERS - 1);
    send_measured(t);
    send_measured(t);
    for (int k = 0; k < extra; k++) send_word(TRK_W'(t), 1'b0, noise_vec());
  endtask

  initial begin : stimulus
    int lims [3];
    int span;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.tracker_id = '0;
    in_ch.measured_ok = 1'b0;
    in_ch.meas_x = '0;
    in_ch.meas_y = '0;
    in_ch.meas_z = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.max_dropout_frames = '0;
    for (int t = 0; t < NUM_TRACKERS; t++) begin
      drop_left[t] = 0;
      for (int a = 0; a < 3; a++) begin
        walk_pos[t][a] = coord_t'(int'($urandom_range(0, 65536)) - 32768);
        walk_vel[t][a] = coord_t'(int'($urandom_range(0, 512)) - 256);
      end
    end
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_idle_pct = 21;
    recv_idle_pct = 58;

    // directed: limit still at its reset value of zero
    send_word(3'd0, 1'b0, vec3(5, 6, 7));
    send_word(3'd5, 1'b1, vec3(COORD_MAX, COORD_MIN, '1));
    send_word(3'd7, 1'b0, vec3('1, '1, '1));
    send_word(3'd0, 1'b1, vec3(COORD_MIN, COORD_MAX, 0));
    send_word(3'd0, 1'b1, vec3(COORD_MAX, COORD_MIN, '1));
    send_word(3'd0, 1'b0, vec3(1, 2, 3));
    send_word(3'd1, 1'b1, vec3(100, 200, 300));
    send_word(3'd1, 1'b0, vec3(0, 0, 0));
    drain();
    write_limit(8'd255);
    // saturating extrapolation, then single-entry history
    send_word(3'd0, 1'b0, vec3(0, 0, 0));
    send_word(3'd0, 1'b0, vec3(0, 0, 0));
    send_word(3'd1, 1'b0, vec3(0, 0, 0));
    send_word(3'd1, 1'b1, vec3(150, 150, 250));
    send_word(3'd1, 1'b0, vec3(0, 0, 0));
    drain();
    write_limit(8'd2);
    // dropout budget runs out, then a measurement restarts it
    send_word(3'd2, 1'b1, vec3(0, 0, 0));
    send_word(3'd2, 1'b1, vec3(256, -256, 1024));
    send_word(3'd2, 1'b0, vec3(0, 0, 0));
    send_word(3'd2, 1'b0, vec3(0, 0, 0));
    send_word(3'd2, 1'b0, vec3(0, 0, 0));
    send_word(3'd2, 1'b1, vec3(-512, 512, 0));
    send_word(3'd2, 1'b0, vec3(0, 0, 0));
    send_word(3'd6, 1'b1, vec3(COORD_MIN, COORD_MIN, COORD_MIN));
    send_word(3'd3, 1'b1, vec3('1, 0, COORD_MAX));
    send_word(3'd3, 1'b1, vec3(0, '1, COORD_MIN));
    send_word(3'd3, 1'b0, vec3(0, 0, 0));

    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin
          send_idle_pct = 21;
          recv_idle_pct = 58;
          lims[0] = 1;
          lims[1] = 255;
          lims[2] = 4;
        end
        1: begin
          send_idle_pct = 58;
          recv_idle_pct = 21;
          lims[0] = 0;
          lims[1] = $urandom_range(2, 254);
          lims[2] = 2;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          lims[0] = 255;
          lims[1] = $urandom_range(1, 255);
          lims[2] = 6;
        end
      endcase
      for (int sub = 0; sub < 3; sub++) begin
        drain();
        write_limit(CNT_W'(lims[sub]));
        for (int t = 0; t < NUM_TRACKERS; t++) drop_left[t] = 0;
        if (sub == 0) hold_request = HOLD_CYCLES;
        if (lims[sub] == 255) long_dropout(lims[sub] + 3);
        span = (lims[sub] + 3 < 12) ? lims[sub] + 3 : 12;
        run_random(180, span);
      end
    end

    drain();
    if (poses.failures == 0 && poses.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

### tracker_dropout_extrapolator.f
rtl/tde_pkg.sv
rtl/tde_ifs.sv
rtl/tde_ram.sv
rtl/tde_update.sv
rtl/tde_extrap.sv
rtl/tracker_dropout_extrapolator.sv
bench/testbench.sv
